// ===== src/dle_pkg.sv =====
// Package with shared types and constants of the escaped frame decoder.
package dle_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [1:0] REG_START_BYTE  = 2'd0;
   localparam logic [1:0] REG_ESCAPE_BYTE = 2'd1;
   localparam logic [1:0] REG_END_BYTE    = 2'd2;
   localparam logic [1:0] REG_MIN_ANSWER  = 2'd3;

   localparam logic [7:0] RESET_START_BYTE  = 8'd2;
   localparam logic [7:0] RESET_ESCAPE_BYTE = 8'd16;
   localparam logic [7:0] RESET_END_BYTE    = 8'd3;
   localparam logic [7:0] RESET_MIN_ANSWER  = 8'd5;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_SHORT_BUF   = 3'd1;
   localparam logic [2:0] ST_NO_START    = 3'd2;
   localparam logic [2:0] ST_SHORT_FRAME = 3'd3;
   localparam logic [2:0] ST_MISSING_END = 3'd4;
   localparam logic [2:0] ST_BAD_CHECK   = 3'd5;

   typedef struct packed {
      logic [7:0] start_byte;
      logic [7:0] escape_byte;
      logic [7:0] end_byte;
      logic [7:0] min_answer_bytes;
   } cfg_type;

endpackage

// ===== src/dle_csr.sv =====
// Configuration register file behind the APB-style port.
module dle_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dle_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [dle_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [dle_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready,
   output dle_pkg::cfg_type                    cfg
);
   import dle_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] index;
   logic       write_en;
   logic [7:0] read_byte;

   assign index    = csr_paddr[3:2];
   assign write_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_START_BYTE:  cfg_in.start_byte       = csr_pwdata[7:0];
            REG_ESCAPE_BYTE: cfg_in.escape_byte      = csr_pwdata[7:0];
            REG_END_BYTE:    cfg_in.end_byte         = csr_pwdata[7:0];
            REG_MIN_ANSWER:  cfg_in.min_answer_bytes = csr_pwdata[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_START_BYTE:  read_byte = cfg_ff.start_byte;
         REG_ESCAPE_BYTE: read_byte = cfg_ff.escape_byte;
         REG_END_BYTE:    read_byte = cfg_ff.end_byte;
         REG_MIN_ANSWER:  read_byte = cfg_ff.min_answer_bytes;
         default:         read_byte = 8'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte       <= RESET_START_BYTE;
         cfg_ff.escape_byte      <= RESET_ESCAPE_BYTE;
         cfg_ff.end_byte         <= RESET_END_BYTE;
         cfg_ff.min_answer_bytes <= RESET_MIN_ANSWER;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_prdata = {{(CSR_DATA_WIDTH-8){1'b0}}, read_byte};
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// ===== src/dle_core.sv =====
// Input register, per-byte decode state machine and result register.
module dle_core (
   input  logic             clock,
   input  logic             reset,
   input  dle_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       in_byte,
   input  logic             in_last,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [7:0]       out_byte,
   output logic             out_is_status,
   output logic [2:0]       out_status
);
   import dle_pkg::*;

   typedef enum logic [2:0] {
      PH_HUNT, PH_BODY, PH_ESC, PH_CHECK, PH_PENDING, PH_DONE
   } phase_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   function automatic logic frame_short(input logic [7:0] fb, input logic [7:0] min_b);
      return ({1'b0, fb} + 9'd1) < {1'b0, min_b};
   endfunction

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_last_ff, s1_last_in;
   phase_type  phase_ff, phase_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] fb_ff, fb_in;
   logic [7:0] bb_ff, bb_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_flag_ff, out_flag_in;
   logic [2:0] out_status_ff, out_status_in;

   logic       advance;
   logic       emit;
   logic       emit_status;
   logic [7:0] emit_byte;
   logic [2:0] emit_code;
   logic       clear;
   logic       buf_short;
   logic [7:0] bb_next;
   logic [7:0] fb_sat;
   logic [7:0] fb_end;
   logic       b_start, b_esc, b_end;
   phase_type  phase_step;
   logic [7:0] xor_step;
   logic [7:0] fb_step;

   assign advance  = s1_valid_ff && (!out_valid_ff || out_ready);
   assign in_ready = !s1_valid_ff || advance;

   assign bb_next   = sat_inc(bb_ff);
   assign buf_short = bb_next < cfg.min_answer_bytes;
   assign fb_sat    = sat_inc(fb_ff);
   assign b_start   = s1_byte_ff == cfg.start_byte;
   assign b_esc     = s1_byte_ff == cfg.escape_byte;
   assign b_end     = s1_byte_ff == cfg.end_byte;
   assign fb_end    = (b_esc || b_end) ? fb_sat : fb_ff;

   always_comb begin
      emit        = 1'b0;
      emit_status = 1'b0;
      emit_byte   = 8'd0;
      emit_code   = ST_OK;
      clear       = 1'b0;
      phase_step  = phase_ff;
      xor_step    = xor_ff;
      fb_step     = fb_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (s1_last_ff) begin
               emit        = 1'b1;
               emit_status = 1'b1;
               emit_code   = buf_short ? ST_SHORT_BUF : ST_NO_START;
               clear       = 1'b1;
            end else if (b_start) begin
               phase_step = PH_BODY;
               xor_step   = 8'd0;
               fb_step    = 8'd0;
            end
         end
         PH_BODY: begin
            if (s1_last_ff) begin
               emit        = 1'b1;
               emit_status = 1'b1;
               emit_code   = buf_short ? ST_SHORT_BUF :
                             frame_short(fb_ff, cfg.min_answer_bytes) ? ST_SHORT_FRAME :
                             ST_MISSING_END;
               clear       = 1'b1;
            end else begin
               fb_step  = fb_sat;
               xor_step = xor_ff ^ s1_byte_ff;
               if (b_esc) begin
                  phase_step = PH_ESC;
               end else if (b_end) begin
                  phase_step = PH_CHECK;
               end else begin
                  emit      = 1'b1;
                  emit_byte = s1_byte_ff;
               end
            end
         end
         PH_ESC: begin
            if (s1_last_ff) begin
               emit        = 1'b1;
               emit_status = 1'b1;
               emit_code   = buf_short ? ST_SHORT_BUF :
                             frame_short(fb_end, cfg.min_answer_bytes) ? ST_SHORT_FRAME :
                             ST_MISSING_END;
               clear       = 1'b1;
            end else begin
               fb_step    = fb_sat;
               xor_step   = xor_ff ^ s1_byte_ff;
               phase_step = PH_BODY;
               emit       = 1'b1;
               emit_byte  = s1_byte_ff;
            end
         end
         PH_CHECK: begin
            fb_step = fb_sat;
            if (!s1_last_ff && buf_short) begin
               phase_step = PH_PENDING;
            end else begin
               emit        = 1'b1;
               emit_status = 1'b1;
               emit_code   = buf_short ? ST_SHORT_BUF :
                             frame_short(fb_sat, cfg.min_answer_bytes) ? ST_SHORT_FRAME :
                             (s1_byte_ff == xor_ff) ? ST_OK : ST_BAD_CHECK;
               clear       = s1_last_ff;
               phase_step  = PH_DONE;
            end
         end
         PH_PENDING: begin
            if (s1_last_ff) begin
               emit        = 1'b1;
               emit_status = 1'b1;
               emit_code   = buf_short ? ST_SHORT_BUF : ST_SHORT_FRAME;
               clear       = 1'b1;
            end
         end
         PH_DONE: begin
            clear = s1_last_ff;
         end
         default: begin
            clear = 1'b1;
         end
      endcase
   end

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_byte_in    = s1_byte_ff;
      s1_last_in    = s1_last_ff;
      phase_in      = phase_ff;
      xor_in        = xor_ff;
      fb_in         = fb_ff;
      bb_in         = bb_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_flag_in   = out_flag_ff;
      out_status_in = out_status_ff;
      if (in_ready) begin
         s1_valid_in = in_valid;
         s1_byte_in  = in_byte;
         s1_last_in  = in_last;
      end
      if (advance) begin
         if (clear) begin
            phase_in = PH_HUNT;
            xor_in   = 8'd0;
            fb_in    = 8'd0;
            bb_in    = 8'd0;
         end else begin
            phase_in = phase_step;
            xor_in   = xor_step;
            fb_in    = fb_step;
            bb_in    = bb_next;
         end
         out_valid_in  = emit;
         out_byte_in   = emit_byte;
         out_flag_in   = emit_status;
         out_status_in = emit_code;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff    <= s1_byte_in;
      s1_last_ff    <= s1_last_in;
      out_byte_ff   <= out_byte_in;
      out_flag_ff   <= out_flag_in;
      out_status_ff <= out_status_in;
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= PH_HUNT;
         xor_ff       <= 8'd0;
         fb_ff        <= 8'd0;
         bb_ff        <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         phase_ff     <= phase_in;
         xor_ff       <= xor_in;
         fb_ff        <= fb_in;
         bb_ff        <= bb_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_byte      = out_byte_ff;
   assign out_is_status = out_flag_ff;
   assign out_status    = out_status_ff;

   a_eob_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff) |=> (phase_ff == PH_HUNT && bb_ff == 8'd0 && fb_ff == 8'd0))
      else $error("End of buffer did not return the decoder to hunting.");

   a_hunt_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT) |-> (fb_ff == 8'd0 && xor_ff == 8'd0))
      else $error("Frame counters are not clear while hunting.");

   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (advance && phase_ff == PH_DONE) |=> !out_valid_ff)
      else $error("A word after a completed frame produced a result.");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && emit && !emit_status) |=> (out_status_ff == ST_OK))
      else $error("A data word carries a nonzero status.");

endmodule

// ===== src/dle_escaped_frame_decoder.sv =====
// Top level of the escaped frame decoder: configuration registers and decode core.
//
//  Channel  Direction  Handshake              Payload
//  req      in         req_tvalid/req_tready  tdata: rx_byte; tlast: end_of_buffer
//  rsp      out        rsp_tvalid/rsp_tready  tdata: byte_value; tuser: is_status, frame_status
//  csr      in/out     psel/penable, pready   four 8-bit registers at byte addresses 0 to 12
//
// Each word passes through the input register and then into the result register,
// and a new word is taken every cycle while results are drained.
// The input register keeps accepting one word while a result waits to be taken.
// Reset clears the decode state, the valid flags and the configuration registers to their defaults.
module dle_escaped_frame_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // rx_byte
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // byte_value
   output logic [3:0]                          rsp_tuser,   // frame_status[2:0], is_status
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dle_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [dle_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [dle_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import dle_pkg::*;

   cfg_type    cfg;
   logic       is_status;
   logic [2:0] frame_status;

   dle_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dle_core u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_byte       (req_tdata),
      .in_last       (req_tlast),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_byte      (rsp_tdata),
      .out_is_status (is_status),
      .out_status    (frame_status)
   );

   assign rsp_tuser = {frame_status, is_status};

endmodule
